// ===== hdl/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg: shared types and codes of the deduplicating event table.
// Holds the entry record layout, operation codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package det_pkg;

	// Ages saturate at the top of their 24-bit range.
	localparam logic [23:0] AGE_MAX = 24'hFFFFFF;

	// Operation codes carried by the action field.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_TAKE   = 2'd2;
	localparam logic [1:0] ACT_LOOKUP = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_NEW   = 3'd0;
	localparam logic [2:0] ST_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_NONE  = 3'd3;
	localparam logic [2:0] ST_TICK  = 3'd4;

	// One table entry as stored in the entry memory.
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] other_id;
		logic [7:0]  cause;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [23:0] age;
		logic        served;
	} entry_t;

endpackage

`default_nettype wire

// ===== hdl/det_ram.sv =====
// ----------------------------------------------------------------------------
// det_ram: entry memory of the event table.
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module det_ram #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [IW-1:0]   waddr,
	input  wire det_pkg::entry_t wdata,
	input  wire logic [IW-1:0]   raddr,
	output det_pkg::entry_t      rdata
);

	det_pkg::entry_t mem [DEPTH];
	det_pkg::entry_t rdata_q;

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/dedup_event_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// dedup_event_table_with_aging: packed event table keyed by id, with aging.
// Insert deduplicates by key, lookup finds by key, tick ages and reaps
// served entries, take-next serves the oldest unserved entry.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_stall  | action and entry fields
//  out     | output    | out_valid / out_stall| status, entry, reaped_count
//  cfg     | input     | cfg_valid / cfg_ready| linger_time
//
// Every operation walks the stored entries through the entry memory, each
// entry read, then checked; insert and lookup stop at the first key match.
// A tick passes through a move step for each entry it removes, except when the
// removed entry is the last one. The registered read of the entry
// memory sets the pace. Reset clears the entry count, the linger register
// and the control state. A stalled result stays in the output register
// while the next word is taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_event_table_with_aging #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] event_key,
	input  wire logic [31:0] partner_id,
	input  wire logic [7:0]  cause,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic signed [15:0] elapsed,
	// result words
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      out_event_key,
	output logic [31:0]      out_partner_id,
	output logic [7:0]       out_cause,
	output logic [31:0]      out_pos_x,
	output logic [31:0]      out_pos_y,
	output logic [31:0]      out_pos_z,
	output logic [23:0]      out_age,
	output logic             out_served,
	output logic [4:0]       reaped_count,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] cfg_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHK, S_MOVE, S_RES} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   idx_q;
	logic [23:0]     linger_q;
	logic [1:0]      op_q;
	logic [31:0]     key_q;
	det_pkg::entry_t new_q;
	logic [14:0]     dt_q;
	logic [4:0]      reap_q;
	logic            best_vld_q;
	logic [IW-1:0]   best_idx_q;
	det_pkg::entry_t best_q;
	logic [2:0]      res_status_q;
	det_pkg::entry_t res_entry_q;
	logic [4:0]      res_reap_q;
	logic            out_valid_q;
	logic [2:0]      out_status_q;
	det_pkg::entry_t out_entry_q;
	logic [4:0]      out_reap_q;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	det_pkg::entry_t ram_wdata;
	logic [IW-1:0]   ram_raddr;
	det_pkg::entry_t rdata;

	logic [24:0]     age_sum;
	logic [23:0]     aged;
	logic            reap;
	logic [CW-1:0]   last_idx;
	logic            scan_end;
	logic            full;
	logic            take_cand;
	logic            slot_free;
	logic            in_acc;
	det_pkg::entry_t best_srv;

	det_ram #(.DEPTH(DEPTH), .IW(IW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Entry checks on the word just read from memory.
	assign age_sum   = {1'b0, rdata.age} + 25'(dt_q);
	assign aged      = age_sum[24] ? det_pkg::AGE_MAX : age_sum[23:0];
	assign reap      = rdata.served && (aged >= linger_q);
	assign last_idx  = cnt_q - CW'(1);
	assign scan_end  = (idx_q == cnt_q);
	assign full      = (cnt_q == CW'(DEPTH));
	assign take_cand = !rdata.served && (!best_vld_q || (rdata.age > best_q.age));
	assign slot_free = !out_valid_q || !out_stall;
	assign in_acc    = in_valid && !in_stall;

	// The chosen oldest entry as it reads once it is marked served.
	always_comb begin
		best_srv        = best_q;
		best_srv.served = 1'b1;
	end

	// Memory addressing and write-back.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = rdata;
		ram_raddr = idx_q[IW-1:0];
		unique case (state_q)
			S_SCAN: begin
				if (scan_end && (op_q == det_pkg::ACT_INSERT) && !full) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[IW-1:0];
					ram_wdata = new_q;
				end else if (scan_end && (op_q == det_pkg::ACT_TAKE) && best_vld_q) begin
					ram_we    = 1'b1;
					ram_waddr = best_idx_q;
					ram_wdata = best_srv;
				end
			end
			S_CHK: begin
				if (op_q == det_pkg::ACT_TICK) begin
					if (!reap) begin
						ram_we        = 1'b1;
						ram_wdata.age = aged;
					end else begin
						ram_raddr = last_idx[IW-1:0];
					end
				end
			end
			S_MOVE: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linger_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			linger_q <= cfg_data;
		end
	end

	// Operation sequencer with result staging and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			best_vld_q  <= 1'b0;
		end else begin
			// A result word leaves unless a new one is loaded in this cycle.
			if (out_valid_q && !out_stall && (state_q != S_RES)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q            <= action;
						key_q           <= event_key;
						new_q.key       <= event_key;
						new_q.other_id  <= partner_id;
						new_q.cause     <= cause;
						new_q.pos_x     <= pos_x;
						new_q.pos_y     <= pos_y;
						new_q.pos_z     <= pos_z;
						new_q.age       <= '0;
						new_q.served    <= 1'b0;
						dt_q            <= elapsed[15] ? 15'd0 : elapsed[14:0];
						idx_q           <= '0;
						reap_q          <= '0;
						best_vld_q      <= 1'b0;
						state_q         <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_RES;
						unique case (op_q)
							det_pkg::ACT_INSERT: begin
								res_reap_q <= '0;
								if (full) begin
									res_status_q <= det_pkg::ST_FULL;
									res_entry_q  <= '0;
								end else begin
									res_status_q <= det_pkg::ST_NEW;
									res_entry_q  <= new_q;
									cnt_q        <= cnt_q + CW'(1);
								end
							end
							det_pkg::ACT_TICK: begin
								res_status_q <= det_pkg::ST_TICK;
								res_entry_q  <= '0;
								res_reap_q   <= reap_q;
							end
							det_pkg::ACT_TAKE: begin
								res_reap_q <= '0;
								if (best_vld_q) begin
									res_status_q <= det_pkg::ST_FOUND;
									res_entry_q  <= best_srv;
								end else begin
									res_status_q <= det_pkg::ST_NONE;
									res_entry_q  <= '0;
								end
							end
							det_pkg::ACT_LOOKUP: begin
								res_status_q <= det_pkg::ST_NONE;
								res_entry_q  <= '0;
								res_reap_q   <= '0;
							end
							default: begin
							end
						endcase
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					unique case (op_q)
						det_pkg::ACT_INSERT, det_pkg::ACT_LOOKUP: begin
							if (rdata.key == key_q) begin
								res_status_q <= det_pkg::ST_FOUND;
								res_entry_q  <= rdata;
								res_reap_q   <= '0;
								state_q      <= S_RES;
							end else begin
								idx_q   <= idx_q + CW'(1);
								state_q <= S_SCAN;
							end
						end
						det_pkg::ACT_TICK: begin
							if (reap) begin
								// Remove this entry; the last one moves into its place.
								cnt_q  <= last_idx;
								reap_q <= reap_q + 5'd1;
								if (idx_q == last_idx) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_MOVE;
								end
							end else begin
								idx_q   <= idx_q + CW'(1);
								state_q <= S_SCAN;
							end
						end
						det_pkg::ACT_TAKE: begin
							if (take_cand) begin
								best_vld_q <= 1'b1;
								best_idx_q <= idx_q[IW-1:0];
								best_q     <= rdata;
							end
							idx_q   <= idx_q + CW'(1);
							state_q <= S_SCAN;
						end
						default: begin
						end
					endcase
				end
				S_MOVE: begin
					// The moved entry is checked again at the same index.
					state_q <= S_SCAN;
				end
				S_RES: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_entry_q  <= res_entry_q;
						out_reap_q   <= res_reap_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign out_event_key  = out_entry_q.key;
	assign out_partner_id = out_entry_q.other_id;
	assign out_cause      = out_entry_q.cause;
	assign out_pos_x      = out_entry_q.pos_x;
	assign out_pos_y      = out_entry_q.pos_y;
	assign out_pos_z      = out_entry_q.pos_z;
	assign out_age        = out_entry_q.age;
	assign out_served     = out_entry_q.served;
	assign reaped_count   = out_reap_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the deduplicating event table.
// A directed table covers the empty table, the field extremes, duplicates,
// zero-linger removal and negative elapsed times. Random phases follow under
// several linger settings, one of which drives ages into saturation. Each
// result word is checked against a local model of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int DEPTH = 16;
	localparam int SETTLE = 120;
	localparam longint CYCLE_LIMIT = 3000000;

	// One result word as the block returns it.
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] vid;
		logic [31:0] kid;
		logic [7:0]  cause;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [23:0] age;
		logic        served;
		logic [4:0]  reaped;
	} result_t;

	// One row of the directed part.
	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] vid;
		logic [31:0] kid;
		logic [7:0]  cause;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [15:0] el;
		logic [2:0]  want_status;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = det_pkg::ACT_INSERT;
	logic [31:0] event_key = '0, partner_id = '0, pos_x = '0, pos_y = '0, pos_z = '0;
	logic [7:0] cause = '0;
	logic signed [15:0] elapsed = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [31:0] out_event_key, out_partner_id, out_pos_x, out_pos_y, out_pos_z;
	logic [7:0] out_cause;
	logic [23:0] out_age;
	logic out_served;
	logic [4:0] reaped_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [23:0] cfg_data = '0;

	dedup_event_table_with_aging #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.event_key(event_key), .partner_id(partner_id), .cause(cause),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .elapsed(elapsed),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.out_event_key(out_event_key), .out_partner_id(out_partner_id),
		.out_cause(out_cause), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
		.out_pos_z(out_pos_z), .out_age(out_age), .out_served(out_served),
		.reaped_count(reaped_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Local copy of the table and the linger register.
	det_pkg::entry_t evt_tbl [DEPTH];
	int unsigned evt_count = 0;
	logic [23:0] linger_reg = '0;
	result_t pending_results[$];

	int n_errors = 0;
	int n_checked = 0;
	int n_full = 0;
	int n_reaped = 0;
	int n_saturated = 0;
	bit calm = 1'b0;
	longint cycles = 0;

	// Computes the result of one accepted word and updates the local table.
	function automatic result_t table_apply(input logic [1:0] act, input logic [31:0] key,
			input logic [31:0] kid, input logic [7:0] cs, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] pz, input logic [15:0] el);
		result_t r;
		int hit;
		int best;
		int unsigned i;
		logic [24:0] sum;
		logic [23:0] dt;
		logic [23:0] oldest;
		r = '0;
		hit = -1;
		best = -1;
		oldest = '0;
		if (act == det_pkg::ACT_INSERT || act == det_pkg::ACT_LOOKUP) begin
			for (i = 0; i < evt_count; i++)
				if (hit < 0 && evt_tbl[i].key == key)
					hit = i;
		end
		case (act)
			det_pkg::ACT_INSERT: begin
				if (hit >= 0) begin
					best = hit;
					r.status = det_pkg::ST_FOUND;
				end else if (evt_count >= DEPTH) begin
					r.status = det_pkg::ST_FULL;
					n_full++;
				end else begin
					evt_tbl[evt_count] = '{key: key, other_id: kid, cause: cs, pos_x: px,
						pos_y: py, pos_z: pz, age: '0, served: 1'b0};
					best = evt_count;
					evt_count++;
					r.status = det_pkg::ST_NEW;
				end
			end
			det_pkg::ACT_TICK: begin
				// Negative elapsed counts as zero; ages saturate.
				dt = el[15] ? 24'd0 : {8'd0, el};
				i = 0;
				while (i < evt_count) begin
					sum = {1'b0, evt_tbl[i].age} + {1'b0, dt};
					evt_tbl[i].age = sum[24] ? det_pkg::AGE_MAX : sum[23:0];
					if (evt_tbl[i].age == det_pkg::AGE_MAX)
						n_saturated++;
					if (evt_tbl[i].served && evt_tbl[i].age >= linger_reg) begin
						evt_count--;
						evt_tbl[i] = evt_tbl[evt_count];
						r.reaped++;
						n_reaped++;
					end else begin
						i++;
					end
				end
				r.status = det_pkg::ST_TICK;
			end
			det_pkg::ACT_TAKE: begin
				// Oldest unserved entry, lowest index on ties.
				for (i = 0; i < evt_count; i++)
					if (!evt_tbl[i].served && (best < 0 || evt_tbl[i].age > oldest)) begin
						oldest = evt_tbl[i].age;
						best = i;
					end
				if (best >= 0) begin
					evt_tbl[best].served = 1'b1;
					r.status = det_pkg::ST_FOUND;
				end else begin
					r.status = det_pkg::ST_NONE;
				end
			end
			default: begin
				best = hit;
				r.status = (hit >= 0) ? det_pkg::ST_FOUND : det_pkg::ST_NONE;
			end
		endcase
		if (best >= 0) begin
			r.vid = evt_tbl[best].key;
			r.kid = evt_tbl[best].other_id;
			r.cause = evt_tbl[best].cause;
			r.x = evt_tbl[best].pos_x;
			r.y = evt_tbl[best].pos_y;
			r.z = evt_tbl[best].pos_z;
			r.age = evt_tbl[best].age;
			r.served = evt_tbl[best].served;
		end
		return r;
	endfunction

	// Random gap length: mostly short, a few long, none while calm.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one input word and records its expected result on acceptance.
	task automatic send_word(input logic [1:0] act, input logic [31:0] key,
			input logic [31:0] kid, input logic [7:0] cs, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] pz, input logic [15:0] el,
			output result_t predicted);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		event_key <= key;
		partner_id <= kid;
		cause <= cs;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		elapsed <= el;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		predicted = table_apply(act, key, kid, cs, px, py, pz, el);
		pending_results.push_back(predicted);
		@(negedge clk);
	endtask

	// Waits until every expected word has come back and the block is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Writes the linger register while the block is idle.
	task automatic write_linger(input logic [23:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		linger_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random stall on the result side, with bursts of both lengths.
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
				: $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endtask

	// Compares each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected, status %0d", status);
				n_errors++;
			end else begin
				w = pending_results.pop_front();
				n_checked++;
				check_field("status", 32'(w.status), 32'(status));
				check_field("out_event_key", w.vid, out_event_key);
				check_field("out_partner_id", w.kid, out_partner_id);
				check_field("out_cause", 32'(w.cause), 32'(out_cause));
				check_field("out_pos_x", w.x, out_pos_x);
				check_field("out_pos_y", w.y, out_pos_y);
				check_field("out_pos_z", w.z, out_pos_z);
				check_field("out_age", 32'(w.age), 32'(out_age));
				check_field("out_served", 32'(w.served), 32'(out_served));
				check_field("reaped_count", 32'(w.reaped), 32'(reaped_count));
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Random words in one phase: keys from a small pool so duplicates,
	// hits and a full table are common.
	task automatic random_phase(input int n_words, input int tick_pct,
			input bit max_elapsed);
		int k;
		int p;
		logic [1:0] act;
		logic [31:0] key;
		logic [15:0] el;
		result_t r;
		for (k = 0; k < n_words; k++) begin
			p = $urandom_range(0, 99);
			if (p < tick_pct)
				act = det_pkg::ACT_TICK;
			else if (p < tick_pct + (100 - tick_pct) * 45 / 100)
				act = det_pkg::ACT_INSERT;
			else if (p < tick_pct + (100 - tick_pct) * 75 / 100)
				act = det_pkg::ACT_TAKE;
			else
				act = det_pkg::ACT_LOOKUP;
			key = ($urandom_range(0, 9) < 8) ? 32'h1000 + $urandom_range(0, 23) : $urandom;
			p = $urandom_range(0, 9);
			if (max_elapsed)
				el = 16'sd32767;
			else if (p < 5)
				el = 16'($urandom_range(0, 300));
			else
				el = 16'($urandom);
			if (k == n_words / 2)
				drain();
			calm = (k % 150) > 120;
			send_word(act, key, $urandom, 8'($urandom_range(0, 255)), $urandom, $urandom,
				$urandom, el, r);
		end
		calm = 1'b0;
	endtask

	dir_row_t dir_rows[$];

	task automatic add_row(input logic [1:0] act, input logic [31:0] key,
			input logic [31:0] fill, input logic [15:0] el, input logic [2:0] st);
		dir_rows.push_back('{act: act, vid: key, kid: fill, cause: fill[7:0], x: fill,
			y: ~fill, z: fill, el: el, want_status: st});
	endtask

	initial begin
		result_t r;
		// Directed words: empty table, extremes, duplicates, zero linger.
		add_row(det_pkg::ACT_LOOKUP, 32'd5, 32'h0, 16'd0, det_pkg::ST_NONE);
		add_row(det_pkg::ACT_TAKE, 32'd0, 32'h0, 16'd0, det_pkg::ST_NONE);
		add_row(det_pkg::ACT_TICK, 32'd0, 32'h0, 16'd100, det_pkg::ST_TICK);
		add_row(det_pkg::ACT_INSERT, 32'h0, 32'h0, 16'd0, det_pkg::ST_NEW);
		add_row(det_pkg::ACT_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, det_pkg::ST_NEW);
		add_row(det_pkg::ACT_INSERT, 32'h0, 32'hA5A5A5A5, 16'd0, det_pkg::ST_FOUND);
		add_row(det_pkg::ACT_LOOKUP, 32'hFFFFFFFF, 32'h0, 16'd0, det_pkg::ST_FOUND);
		add_row(det_pkg::ACT_TICK, 32'd0, 32'h0, 16'sd32767, det_pkg::ST_TICK);
		add_row(det_pkg::ACT_TAKE, 32'd0, 32'h0, 16'd0, det_pkg::ST_FOUND);
		add_row(det_pkg::ACT_TICK, 32'd0, 32'h0, 16'd0, det_pkg::ST_TICK);
		add_row(det_pkg::ACT_LOOKUP, 32'h0, 32'h0, 16'd0, det_pkg::ST_NONE);
		add_row(det_pkg::ACT_TICK, 32'd0, 32'h0, 16'h8000, det_pkg::ST_TICK);
		add_row(det_pkg::ACT_TICK, 32'd0, 32'h0, 16'hFFFF, det_pkg::ST_TICK);
		add_row(det_pkg::ACT_INSERT, 32'h12345678, 32'h5A5A5A5A, 16'd7, det_pkg::ST_NEW);
		add_row(det_pkg::ACT_TAKE, 32'd0, 32'h0, 16'd0, det_pkg::ST_FOUND);
		add_row(det_pkg::ACT_TAKE, 32'd0, 32'h0, 16'd0, det_pkg::ST_FOUND);
		add_row(det_pkg::ACT_TAKE, 32'd0, 32'h0, 16'd0, det_pkg::ST_NONE);
		add_row(det_pkg::ACT_TICK, 32'd0, 32'h0, 16'd1, det_pkg::ST_TICK);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_linger(24'd0);
		foreach (dir_rows[k]) begin
			send_word(dir_rows[k].act, dir_rows[k].vid, dir_rows[k].kid, dir_rows[k].cause,
				dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].el, r);
			if (r.status !== dir_rows[k].want_status) begin
				$error("directed row %0d: status expected %0d, model gives %0d",
					k, dir_rows[k].want_status, r.status);
				n_errors++;
			end
		end

		// Random phases under several linger settings.
		random_phase(250, 25, 1'b0);
		write_linger(24'hFFFFFF);
		random_phase(560, 95, 1'b1);
		random_phase(60, 20, 1'b0);
		write_linger(24'd100);
		random_phase(190, 30, 1'b0);
		write_linger(24'($urandom));
		random_phase(190, 30, 1'b0);
		write_linger(24'd5000);
		random_phase(190, 30, 1'b0);
		drain();

		$display("Checked %0d result words: %0d full, %0d entries removed by ticks,",
			n_checked, n_full, n_reaped);
		$display("%0d saturated ages seen, across five linger settings.", n_saturated);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
